[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the keyframe sequence timer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define KST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define KST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/kst_pkg.sv]
// Package for the keyframe sequence timer: widths, codes, sequencer states
// and the request/status structs of the serial divider. No dependencies.
package kst_pkg;

  localparam int KST_MAX_FRAMES = 16;

  localparam int ACC_W      = 32;
  localparam int DUR_W      = 16;
  localparam int SCALE_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int DIVIDEND_W = DUR_W + FRAC_W;
  localparam int DIVISOR_W  = SCALE_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
  localparam int CUR_W      = 6;
  localparam int SHOWN_W    = 5;
  localparam int ELAPSED_W  = 16;
  localparam int SLOT_W     = 4;
  localparam int ACTION_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int TIME_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // input request kinds
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_HOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd4;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DECIDE,
    ST_READ,
    ST_DIV,
    ST_STEP,
    ST_OUT
  } kst_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } kst_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } kst_div_stat_t;

endpackage

[hdl/kst_divider.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on kst_pkg for widths and the request/status structs.
module kst_divider import kst_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  kst_div_req_t  req,
  output kst_div_stat_t stat
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  // trial subtract of the shifted remainder
  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? DIVISOR_W'(shifted - {1'b0, dvs_r}) : shifted[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule

[hdl/kst_frame_mem.sv]
// Frame duration table: one write port, one registered read port.
// Depends on kst_pkg for the duration width.
module kst_frame_mem import kst_pkg::*; #(
  parameter int DEPTH = KST_MAX_FRAMES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [DUR_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [DUR_W-1:0] rd_data
);

  logic [DUR_W-1:0] mem [DEPTH];
  logic [DUR_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/keyframe_sequence_timer.sv]
// Keyframe sequence timer: steps a frame index on elapsed-time tick requests.
// A load or restart request completes in the idle state. A tick in the middle
// phase passes accept, add, decide, table read, a wait on the serial divider
// that scales the frame duration by 256/speed_scale until it reports done,
// step and output; in the start-delay and end-hold phases it passes accept,
// add, decide and output. The input is not ready while a tick is in work.
// A result waits in the output register while the next request is taken; a
// tick that finds that register still full holds in its output state until
// the result is taken.
// Depends on kst_pkg, kst_divider, kst_frame_mem and assert_macros.svh.
`include "assert_macros.svh"

module keyframe_sequence_timer import kst_pkg::*; #(
  parameter int MAX_FRAMES = KST_MAX_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] elapsed, [19:16] slot, [35:20] duration, [39:36] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [ACTION_W-1:0]   in_tuser,
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [4:0] shown_frame, [5] done_res, [7:6] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  kst_state_t state_r, state_nxt;

  logic [COUNT_W-1:0]    frame_count_r;
  logic                  loop_enable_r;
  logic [TIME_W-1:0]     start_delay_r;
  logic [TIME_W-1:0]     end_hold_r;
  logic [SCALE_W-1:0]    speed_scale_r;

  logic [ACC_W-1:0]      accum_r, accum_nxt;
  logic [CUR_W-1:0]      cur_r, cur_nxt;
  logic                  done_flag_r, done_nxt;
  logic [SHOWN_W-1:0]    shown_r, shown_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [ELAPSED_W-1:0]  in_elapsed;
  logic [SLOT_W-1:0]     in_slot;
  logic [DUR_W-1:0]      in_duration;

  logic [COUNT_W-1:0]    cnt;
  logic [COUNT_W-1:0]    cur_inc;
  logic [ACC_W:0]        sum;
  logic [ACC_W-1:0]      sub_b;
  logic [ACC_W:0]        diff;
  logic                  acc_gt;
  logic                  mem_we;
  logic [DUR_W-1:0]      mem_rd;
  kst_div_req_t          div_req;
  kst_div_stat_t         div_stat;

  assign in_elapsed  = in_tdata[15:0];
  assign in_slot     = in_tdata[19:16];
  assign in_duration = in_tdata[35:20];

  // frame count clamped to the table size
  assign cnt = (int'(frame_count_r) > MAX_FRAMES) ? COUNT_W'(MAX_FRAMES) : frame_count_r;

  // add, and compare-subtract shared by the start-delay decision and the step
  assign sum     = {1'b0, accum_r} + {{(ACC_W-ELAPSED_W+1){1'b0}}, elapsed_r};
  assign sub_b   = (state_r == ST_STEP)
                 ? {{(ACC_W-DIVIDEND_W){1'b0}}, div_stat.quotient}
                 : {{(ACC_W-TIME_W){1'b0}}, start_delay_r};
  assign diff    = {1'b0, accum_r} - {1'b0, sub_b};
  assign acc_gt  = !diff[ACC_W] && (diff[ACC_W-1:0] != '0);
  assign cur_inc = cur_r[COUNT_W-1:0] + 1'b1;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    accum_nxt        = accum_r;
    cur_nxt          = cur_r;
    done_nxt         = done_flag_r;
    shown_nxt        = shown_r;
    elapsed_nxt      = elapsed_r;
    out_valid_nxt    = out_valid_r & ~out_tready;
    out_data_nxt     = out_data_r;
    mem_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {mem_rd, {FRAC_W{1'b0}}};
    div_req.divisor  = (speed_scale_r == '0) ? DIVISOR_W'(1) : speed_scale_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            ACT_TICK: begin
              elapsed_nxt = in_elapsed;
              state_nxt   = ST_ADD;
            end
            ACT_LOAD: begin
              mem_we = int'(in_slot) < MAX_FRAMES;
            end
            ACT_RESTART: begin
              cur_nxt   = '1;
              accum_nxt = '0;
              done_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        // saturating accumulate
        accum_nxt = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (cur_r[CUR_W-1]) begin
          // start-delay phase
          if (acc_gt) begin
            accum_nxt = diff[ACC_W-1:0];
            cur_nxt   = '0;
            shown_nxt = '0;
          end else begin
            shown_nxt = '1;
          end
          state_nxt = ST_OUT;
        end else if (cur_r[COUNT_W-1:0] >= cnt) begin
          // end-hold phase
          if (accum_r < {{(ACC_W-TIME_W){1'b0}}, end_hold_r}) begin
            shown_nxt = cnt - 1'b1;
          end else begin
            done_nxt  = 1'b1;
            shown_nxt = '1;
          end
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        // advance once the scaled duration is exceeded
        shown_nxt = cur_r[SHOWN_W-1:0];
        if (acc_gt) begin
          accum_nxt = diff[ACC_W-1:0];
          if (cur_inc >= cnt) begin
            if (loop_enable_r) begin
              cur_nxt   = '0;
              shown_nxt = '0;
            end else begin
              cur_nxt   = {1'b0, cur_inc};
              shown_nxt = cnt - 1'b1;
            end
          end else begin
            cur_nxt   = {1'b0, cur_inc};
            shown_nxt = cur_inc;
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W-SHOWN_W-1){1'b0}}, done_flag_r, shown_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      accum_r     <= '0;
      cur_r       <= '1;
      done_flag_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      accum_r     <= accum_nxt;
      cur_r       <= cur_nxt;
      done_flag_r <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shown_r    <= shown_nxt;
    elapsed_r  <= elapsed_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      loop_enable_r <= 1'b0;
      start_delay_r <= '0;
      end_hold_r    <= '0;
      speed_scale_r <= SCALE_ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_COUNT: frame_count_r <= cfg_data[COUNT_W-1:0];
        REG_LOOP_ENABLE: loop_enable_r <= cfg_data[0];
        REG_START_DELAY: start_delay_r <= cfg_data[TIME_W-1:0];
        REG_END_HOLD:    end_hold_r    <= cfg_data[TIME_W-1:0];
        REG_SPEED_SCALE: speed_scale_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  kst_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_slot)),
    .wr_data (in_duration),
    .rd_addr (AW'(cur_r[COUNT_W-1:0])),
    .rd_data (mem_rd)
  );

  kst_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `KST_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_r == ST_DIV)
  `KST_ASSERT_NOW(a_done_has_frame, done_flag_r, !cur_r[CUR_W-1])
  `KST_ASSERT_NEXT(a_tick_starts, in_tvalid && in_tready && in_tuser == ACT_TICK, state_r == ST_ADD)

endmodule
